>>> rtl/sih_pkg.sv
// Package: shared types, constants and codes for the shared IRQ handler table
package sih_pkg;

   localparam int SlotsPerLine = 8;
   localparam int LineCount    = 256;
   localparam int MsiBase      = 64;
   localparam int MsiCount     = 32;
   localparam int SlotBits     = $clog2(SlotsPerLine);
   localparam int LineBits     = 8;
   localparam int AddrBits     = LineBits + SlotBits;
   localparam int MsiBits      = $clog2(MsiCount);

   localparam logic [2:0] CMD_INIT    = 3'd0;
   localparam logic [2:0] CMD_ALLOC   = 3'd1;
   localparam logic [2:0] CMD_RELEASE = 3'd2;
   localparam logic [2:0] CMD_REQUEST = 3'd3;
   localparam logic [2:0] CMD_FREE    = 3'd4;
   localparam logic [2:0] CMD_LEGACY  = 3'd5;
   localparam logic [2:0] CMD_MSI     = 3'd6;
   localparam logic [2:0] CMD_RSVD    = 3'd7;

   localparam logic [1:0] EOI_NONE = 2'd0;
   localparam logic [1:0] EOI_PIC  = 2'd1;
   localparam logic [1:0] EOI_APIC = 2'd2;
   localparam logic [1:0] MSK_NONE   = 2'd0;
   localparam logic [1:0] MSK_UNMASK = 2'd1;
   localparam logic [1:0] MSK_MASK   = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  line;
      logic [15:0] handler_id;
      logic [31:0] context_tag;
      logic        share_ok;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        ok;
      logic [7:0]  vector;
      logic [15:0] call_handler;
      logic [31:0] call_context;
      logic [1:0]  eoi_action;
      logic [1:0]  mask_action;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] handler;
      logic [31:0] context_tag;
      logic        shared;
   } slot_type;

   typedef struct packed {
      logic                we;
      logic [AddrBits-1:0] waddr;
      slot_type            wdata;
      logic [AddrBits-1:0] raddr;
   } mem_ctl_type;

endpackage

>>> rtl/sih_slot_ram.sv
// Slot memory: one write and one registered read port
module sih_slot_ram (
   input  logic                clock,
   input  sih_pkg::mem_ctl_type ctl,
   output sih_pkg::slot_type   rdata
);
   sih_pkg::slot_type mem [sih_pkg::LineCount*sih_pkg::SlotsPerLine];

   always_ff @(posedge clock) begin
      if (ctl.we) mem[ctl.waddr] <= ctl.wdata;
      rdata <= mem[ctl.raddr];
   end
endmodule

>>> rtl/shared_irq_handler_table.sv
// Top level: shared IRQ handler table with MSI vector allocator
//
// Requests enter on req_valid/req_stall as one packed req_type; results leave
// on rsp_valid/rsp_stall as rsp_type, one or more per request, the final one
// flagged with last. The apic_enabled register is written through csr_we.
// Only one request is in flight. Release, request, free and dispatch first walk
// the eight slots of the line through the slot memory, one read per cycle, with
// a registered read port. Release, request and free give their result once this
// walk is done. Dispatch then reads the slots again and emits one result per
// occupied slot, one per cycle while rsp_stall is low, followed by the
// completion; a line that is not walked again gets only the completion. Alloc
// answers without a walk. Init clears the slot memory one entry per cycle and
// then completes. After reset the same clearing pass runs before the first
// request is taken. The result register holds while rsp_stall is high and the
// dispatch walk pauses behind it.
module shared_irq_handler_table (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sih_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sih_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam int SB = sih_pkg::SlotBits;
   localparam int AB = sih_pkg::AddrBits;

   logic [2:0]             state_ff, state_in;
   logic [AB-1:0]          clr_ff, clr_in;
   logic                   ready_ff, ready_in;
   logic                   apic_ff;
   logic [sih_pkg::MsiCount-1:0] msi_ff, msi_in;
   sih_pkg::req_type       req_ff, req_in;
   logic [SB:0]            idx_ff, idx_in;   // slot being read
   logic                   rv_ff, rv_in;     // read data valid for slot idx_ff-1
   logic                   used_ff, used_in, allsh_ff, allsh_in, ffree_ff, ffree_in;
   logic [SB-1:0]          fslot_ff, fslot_in, hit_ff, hit_in;
   logic                   hitv_ff, hitv_in;
   logic                   others_ff, others_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sih_pkg::rsp_type       rsp_ff, rsp_in;
   sih_pkg::mem_ctl_type   ctl;
   sih_pkg::slot_type      rdata;

   sih_slot_ram u_ram (.clock(clock), .ctl(ctl), .rdata(rdata));

   logic        is_msi, supp, hz;
   logic [SB-1:0] cur;
   logic [sih_pkg::MsiBits-1:0] ffirst;
   logic        fany;
   logic        out_free;

   always_comb begin
      is_msi = ({1'b0, req_ff.line} >= 9'(sih_pkg::MsiBase)) &&
               ({1'b0, req_ff.line} < 9'(sih_pkg::MsiBase + sih_pkg::MsiCount));
      supp   = ((req_ff.line >= 8'd2) && (req_ff.line < 8'd16)) || is_msi;
      hz     = (req_ff.handler_id == '0);
      cur    = SB'(idx_ff - 1'b1);
      fany   = 1'b0;
      ffirst = '0;
      for (int i = sih_pkg::MsiCount - 1; i >= 0; i--) begin
         if (!msi_ff[i]) begin
            fany   = 1'b1;
            ffirst = sih_pkg::MsiBits'(i);
         end
      end
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   function automatic sih_pkg::rsp_type done_rsp(logic ok, logic [7:0] v,
                                                  logic [1:0] e, logic [1:0] m);
      sih_pkg::rsp_type r;
      r = '0;
      r.ok = ok; r.vector = v; r.eoi_action = e; r.mask_action = m; r.last = 1'b1;
      return r;
   endfunction

   function automatic logic walk_active();
      logic a;
      if (req_ff.cmd == sih_pkg::CMD_LEGACY)
         a = ready_ff && req_ff.line >= 8'd2 && req_ff.line < 8'd16;
      else
         a = ready_ff && is_msi;
      return a;
   endfunction

   function automatic logic [1:0] eoi_code();
      logic [1:0] e;
      if (req_ff.cmd == sih_pkg::CMD_MSI) e = sih_pkg::EOI_APIC;
      else if (req_ff.line < 8'd16) e = sih_pkg::EOI_PIC;
      else e = sih_pkg::EOI_NONE;
      return e;
   endfunction

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; ready_in = ready_ff; msi_in = msi_ff;
      req_in = req_ff; idx_in = idx_ff; rv_in = 1'b0;
      used_in = used_ff; allsh_in = allsh_ff; ffree_in = ffree_ff;
      fslot_in = fslot_ff; hit_in = hit_ff; hitv_in = hitv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall; rsp_in = rsp_ff;
      ctl = '0;
      ctl.raddr = {req_ff.line, idx_ff[SB-1:0]};
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.we = 1'b1; ctl.waddr = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ready_ff ? ST_DECIDE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0; used_in = 1'b0; allsh_in = 1'b1; ffree_in = 1'b0;
               hitv_in = 1'b0;
               state_in = ST_DECIDE;
               if (req_data.cmd == sih_pkg::CMD_INIT) begin
                  clr_in = '0; msi_in = '0; ready_in = 1'b1; state_in = ST_CLEAR;
               end else if (req_data.cmd == sih_pkg::CMD_REQUEST ||
                            req_data.cmd == sih_pkg::CMD_FREE ||
                            req_data.cmd == sih_pkg::CMD_RELEASE ||
                            req_data.cmd == sih_pkg::CMD_LEGACY ||
                            req_data.cmd == sih_pkg::CMD_MSI) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue reads for slots 0..N-1, gather the previous slot
            if (rv_ff) begin
               if (rdata.handler == req_ff.handler_id &&
                   rdata.context_tag == req_ff.context_tag && !hitv_ff) begin
                  hitv_in = 1'b1; hit_in = cur;
               end
               if (rdata.handler == '0) begin
                  if (!ffree_ff) begin
                     ffree_in = 1'b1; fslot_in = cur;
                  end
               end else begin
                  used_in = 1'b1;
                  if (!rdata.shared) allsh_in = 1'b0;
               end
            end
            if (idx_ff == (SB+1)'(sih_pkg::SlotsPerLine)) begin
               if (!rv_ff) state_in = ST_DECIDE;
            end else begin
               idx_in = idx_ff + 1'b1;
               rv_in = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_DONE;
               rsp_valid_in = 1'b1;
               rsp_in = done_rsp(1'b0, 8'd0, sih_pkg::EOI_NONE, sih_pkg::MSK_NONE);
               unique case (req_ff.cmd)
                  sih_pkg::CMD_ALLOC: begin
                     if (ready_ff && apic_ff && fany) begin
                        msi_in[ffirst] = 1'b1;
                        rsp_in.ok = 1'b1;
                        rsp_in.vector = 8'(sih_pkg::MsiBase) + 8'(ffirst);
                     end
                  end
                  sih_pkg::CMD_RELEASE: begin
                     if (ready_ff && is_msi && !used_ff)
                        msi_in[sih_pkg::MsiBits'(req_ff.line - 8'(sih_pkg::MsiBase))] = 1'b0;
                  end
                  sih_pkg::CMD_REQUEST: begin
                     if (ready_ff && !hz && supp) begin
                        if (hitv_ff) begin
                           rsp_in.ok = 1'b1;
                        end else if (ffree_ff && !(used_ff && (!req_ff.share_ok || !allsh_ff))) begin
                           ctl.we = 1'b1;
                           ctl.waddr = {req_ff.line, fslot_ff};
                           ctl.wdata = '{req_ff.handler_id, req_ff.context_tag, req_ff.share_ok};
                           rsp_in.ok = 1'b1;
                           rsp_in.mask_action = is_msi ? sih_pkg::MSK_NONE : sih_pkg::MSK_UNMASK;
                        end
                     end
                  end
                  sih_pkg::CMD_FREE: begin
                     if (ready_ff && !hz && supp && hitv_ff) begin
                        ctl.we = 1'b1;
                        ctl.waddr = {req_ff.line, hit_ff};
                        ctl.wdata = '0;
                        rsp_in.ok = 1'b1;
                        rsp_in.mask_action = (!is_msi && !others_ff) ? sih_pkg::MSK_MASK
                                                                     : sih_pkg::MSK_NONE;
                        state_in = ST_DONE;
                     end
                  end
                  sih_pkg::CMD_LEGACY, sih_pkg::CMD_MSI: begin
                     rsp_valid_in = 1'b0;
                     idx_in = '0;
                     state_in = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_EMIT: begin
            // second walk: read slot idx, then emit it from the registered read data
            if (rv_ff) begin
               if (out_free) begin
                  if (rdata.handler != '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '0;
                     rsp_in.kind = 1'b1;
                     rsp_in.call_handler = rdata.handler;
                     rsp_in.call_context = rdata.context_tag;
                  end
               end else begin
                  rv_in = 1'b1;
                  ctl.raddr = {req_ff.line, cur};
               end
            end
            if (!(rv_ff && !out_free)) begin
               if (walk_active() && idx_ff != (SB+1)'(sih_pkg::SlotsPerLine)) begin
                  idx_in = idx_ff + 1'b1;
                  rv_in = 1'b1;
               end else if (!rv_ff && out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = done_rsp(1'b0, 8'd0, eoi_code(), sih_pkg::MSK_NONE);
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // occupancy excluding the freed slot
   always_comb begin
      others_in = others_ff;
      if (state_ff == ST_IDLE) others_in = 1'b0;
      else if (state_ff == ST_SCAN && rv_ff && rdata.handler != '0 &&
               !(rdata.handler == req_ff.handler_id &&
                 rdata.context_tag == req_ff.context_tag && !hitv_ff))
         others_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; ready_ff <= 1'b0; apic_ff <= 1'b0;
         msi_ff <= '0; rsp_valid_ff <= 1'b0; rv_ff <= 1'b0; idx_ff <= '0;
         others_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; ready_ff <= ready_in;
         msi_ff <= msi_in; rsp_valid_ff <= rsp_valid_in; rv_ff <= rv_in;
         idx_ff <= idx_in; others_ff <= others_in;
         if (csr_we) apic_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; used_ff <= used_in; allsh_ff <= allsh_in; ffree_ff <= ffree_in;
      fslot_ff <= fslot_in; hit_ff <= hit_in; hitv_ff <= hitv_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   a_idle_only: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == ST_IDLE)
      else $error("request taken outside idle");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !rsp_data.kind)
      else $error("invoke result flagged last");
endmodule

>>> dv/shared_irq_handler_table_tb.sv
// Testbench: random and directed requests against a behavioural model of the IRQ handler table
module shared_irq_handler_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;
   localparam int TotalSlots = sih_pkg::LineCount * sih_pkg::SlotsPerLine;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sih_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sih_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic             csr_wdata = 1'b0;

   shared_irq_handler_table u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // table model
   logic [15:0] mdl_handler [TotalSlots];
   logic [31:0] mdl_context [TotalSlots];
   logic        mdl_shared  [TotalSlots];
   logic        mdl_taken   [sih_pkg::MsiCount];
   logic        mdl_ready;
   logic        mdl_apic;

   sih_pkg::req_type pending_reqs[$];
   sih_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      hold_off = 0;
   logic    hold_go = 1'b0;
   logic    hold_seen = 1'b0;
   int      idle_cycles = 0;
   int      req_gap = 0;
   int      hold_left = 0;

   function automatic bit is_msi_line(logic [7:0] l);
      return l >= sih_pkg::MsiBase && l < sih_pkg::MsiBase + sih_pkg::MsiCount;
   endfunction

   function automatic bit line_supported(logic [7:0] l);
      return (l >= 2 && l < 16) || is_msi_line(l);
   endfunction

   function automatic bit line_busy(logic [7:0] l);
      for (int i = 0; i < sih_pkg::SlotsPerLine; i++)
         if (mdl_handler[l*sih_pkg::SlotsPerLine+i] != 0) return 1'b1;
      return 1'b0;
   endfunction

   function automatic sih_pkg::rsp_type completion(logic okv, logic [7:0] vec,
                                                   logic [1:0] eoi, logic [1:0] msk);
      sih_pkg::rsp_type r;
      r = '0;
      r.ok = okv;
      r.vector = vec;
      r.eoi_action = eoi;
      r.mask_action = msk;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic push_invokes(logic [7:0] l);
      sih_pkg::rsp_type r;
      if (mdl_ready) begin
         for (int i = 0; i < sih_pkg::SlotsPerLine; i++) begin
            if (mdl_handler[l*sih_pkg::SlotsPerLine+i] != 0) begin
               r = '0;
               r.kind = 1'b1;
               r.call_handler = mdl_handler[l*sih_pkg::SlotsPerLine+i];
               r.call_context = mdl_context[l*sih_pkg::SlotsPerLine+i];
               expected_rsps.push_back(r);
            end
         end
      end
   endtask

   task automatic predict_table(sih_pkg::req_type q);
      int s;
      int free_slot;
      bit used;
      bit every_shared;
      bit done;
      logic okv;
      logic [7:0] vec;
      logic [1:0] msk;
      okv = 1'b0;
      vec = '0;
      msk = sih_pkg::MSK_NONE;
      case (q.cmd)
         sih_pkg::CMD_INIT: begin
            for (int i = 0; i < TotalSlots; i++) begin
               mdl_handler[i] = '0;
               mdl_context[i] = '0;
               mdl_shared[i] = 1'b0;
            end
            for (int i = 0; i < sih_pkg::MsiCount; i++) mdl_taken[i] = 1'b0;
            mdl_ready = 1'b1;
            expected_rsps.push_back(completion(1'b0, '0, sih_pkg::EOI_NONE, sih_pkg::MSK_NONE));
         end
         sih_pkg::CMD_ALLOC: begin
            if (mdl_ready && mdl_apic) begin
               done = 1'b0;
               for (int i = 0; i < sih_pkg::MsiCount; i++) begin
                  if (!done && !mdl_taken[i]) begin
                     mdl_taken[i] = 1'b1;
                     okv = 1'b1;
                     vec = 8'(sih_pkg::MsiBase + i);
                     done = 1'b1;
                  end
               end
            end
            expected_rsps.push_back(completion(okv, vec, sih_pkg::EOI_NONE, sih_pkg::MSK_NONE));
         end
         sih_pkg::CMD_RELEASE: begin
            if (mdl_ready && is_msi_line(q.line) && !line_busy(q.line))
               mdl_taken[q.line - sih_pkg::MsiBase] = 1'b0;
            expected_rsps.push_back(completion(1'b0, '0, sih_pkg::EOI_NONE, sih_pkg::MSK_NONE));
         end
         sih_pkg::CMD_REQUEST: begin
            if (mdl_ready && q.handler_id != 0 && line_supported(q.line)) begin
               used = 1'b0;
               every_shared = 1'b1;
               free_slot = -1;
               done = 1'b0;
               for (int i = 0; i < sih_pkg::SlotsPerLine; i++) begin
                  s = q.line*sih_pkg::SlotsPerLine + i;
                  if (done) continue;
                  if (mdl_handler[s] == q.handler_id && mdl_context[s] == q.context_tag) begin
                     okv = 1'b1;
                     done = 1'b1;
                  end else if (mdl_handler[s] == 0) begin
                     if (free_slot < 0) free_slot = s;
                  end else begin
                     used = 1'b1;
                     if (!mdl_shared[s]) every_shared = 1'b0;
                  end
               end
               if (!done && free_slot >= 0 && !(used && (!q.share_ok || !every_shared))) begin
                  mdl_handler[free_slot] = q.handler_id;
                  mdl_context[free_slot] = q.context_tag;
                  mdl_shared[free_slot] = q.share_ok;
                  okv = 1'b1;
                  msk = is_msi_line(q.line) ? sih_pkg::MSK_NONE : sih_pkg::MSK_UNMASK;
               end
            end
            expected_rsps.push_back(completion(okv, '0, sih_pkg::EOI_NONE, msk));
         end
         sih_pkg::CMD_FREE: begin
            if (mdl_ready && q.handler_id != 0 && line_supported(q.line)) begin
               for (int i = 0; i < sih_pkg::SlotsPerLine; i++) begin
                  s = q.line*sih_pkg::SlotsPerLine + i;
                  if (!okv && mdl_handler[s] == q.handler_id
                      && mdl_context[s] == q.context_tag) begin
                     mdl_handler[s] = '0;
                     mdl_context[s] = '0;
                     mdl_shared[s] = 1'b0;
                     okv = 1'b1;
                  end
               end
               if (okv && !line_busy(q.line) && !is_msi_line(q.line)) msk = sih_pkg::MSK_MASK;
            end
            expected_rsps.push_back(completion(okv, '0, sih_pkg::EOI_NONE, msk));
         end
         sih_pkg::CMD_LEGACY: begin
            if (q.line < 2)
               expected_rsps.push_back(completion(1'b0, '0, sih_pkg::EOI_PIC,
                                                  sih_pkg::MSK_NONE));
            else if (q.line >= 16)
               expected_rsps.push_back(completion(1'b0, '0, sih_pkg::EOI_NONE,
                                                  sih_pkg::MSK_NONE));
            else begin
               push_invokes(q.line);
               expected_rsps.push_back(completion(1'b0, '0, sih_pkg::EOI_PIC,
                                                  sih_pkg::MSK_NONE));
            end
         end
         sih_pkg::CMD_MSI: begin
            if (is_msi_line(q.line)) push_invokes(q.line);
            expected_rsps.push_back(completion(1'b0, '0, sih_pkg::EOI_APIC, sih_pkg::MSK_NONE));
         end
         default: expected_rsps.push_back(completion(1'b0, '0, sih_pkg::EOI_NONE,
                                                     sih_pkg::MSK_NONE));
      endcase
   endtask

   function automatic sih_pkg::req_type make_req(logic [2:0] c, logic [7:0] l,
                                                 logic [15:0] h, logic [31:0] t, logic sh);
      sih_pkg::req_type q;
      q.cmd = c;
      q.line = l;
      q.handler_id = h;
      q.context_tag = t;
      q.share_ok = sh;
      return q;
   endfunction

   function automatic logic [7:0] pick_line();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return 8'($urandom_range(2, 15));
      if (r < 7) return 8'($urandom_range(sih_pkg::MsiBase, sih_pkg::MsiBase + 3));
      if (r < 8)
         return 8'($urandom_range(sih_pkg::MsiBase, sih_pkg::MsiBase + sih_pkg::MsiCount - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_stall) begin
         predict_table(req_data);
         req_gap = $urandom_range(0, 7);
         if (req_gap == 0 && pending_reqs.size() > 0) begin
            req_data <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid && pending_reqs.size() > 0) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
         end else begin
            req_valid <= 1'b1;
            req_data <= pending_reqs.pop_front();
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_off <= 150;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      sih_pkg::rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected response %p", rsp_data);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.kind != e.kind) begin
                  $error("kind exp %0d got %0d", e.kind, rsp_data.kind); errors++;
               end
               if (rsp_data.ok != e.ok) begin
                  $error("ok exp %0d got %0d", e.ok, rsp_data.ok); errors++;
               end
               if (rsp_data.vector != e.vector) begin
                  $error("vector exp %0d got %0d", e.vector, rsp_data.vector); errors++;
               end
               if (rsp_data.call_handler != e.call_handler) begin
                  $error("call_handler exp %h got %h", e.call_handler, rsp_data.call_handler);
                  errors++;
               end
               if (rsp_data.call_context != e.call_context) begin
                  $error("call_context exp %h got %h", e.call_context, rsp_data.call_context);
                  errors++;
               end
               if (rsp_data.eoi_action != e.eoi_action) begin
                  $error("eoi_action exp %0d got %0d", e.eoi_action, rsp_data.eoi_action);
                  errors++;
               end
               if (rsp_data.mask_action != e.mask_action) begin
                  $error("mask_action exp %0d got %0d", e.mask_action, rsp_data.mask_action);
                  errors++;
               end
               if (rsp_data.last != e.last) begin
                  $error("last exp %0d got %0d", e.last, rsp_data.last); errors++;
               end
            end
         end
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            hold_left = $urandom_range(0, 7);
            rsp_stall <= (hold_left != 0);
         end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= (hold_left != 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_apic(logic v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_random(int count);
      logic [2:0] c;
      logic [7:0] l;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         l = pick_line();
         if (r < 2) c = sih_pkg::CMD_INIT;
         else if (r < 12) c = sih_pkg::CMD_ALLOC;
         else if (r < 20) c = sih_pkg::CMD_RELEASE;
         else if (r < 50) c = sih_pkg::CMD_REQUEST;
         else if (r < 65) c = sih_pkg::CMD_FREE;
         else if (r < 80) c = sih_pkg::CMD_LEGACY;
         else if (r < 97) c = sih_pkg::CMD_MSI;
         else c = sih_pkg::CMD_RSVD;
         if ($urandom_range(0, 3) == 0)
            pending_reqs.push_back(make_req(c, l, 16'($urandom), 32'($urandom),
                                            1'($urandom_range(0, 1))));
         else
            pending_reqs.push_back(make_req(c, l, 16'($urandom_range(0, 3)),
                                            32'($urandom_range(0, 1)),
                                            $urandom_range(0, 3) != 0));
      end
   endtask

   initial begin
      for (int i = 0; i < TotalSlots; i++) begin
         mdl_handler[i] = '0;
         mdl_context[i] = '0;
         mdl_shared[i] = 1'b0;
      end
      for (int i = 0; i < sih_pkg::MsiCount; i++) mdl_taken[i] = 1'b0;
      mdl_ready = 1'b0;
      mdl_apic = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // not ready yet: everything fails
      pending_reqs.push_back(make_req(sih_pkg::CMD_ALLOC, 8'd0, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_REQUEST, 8'd5, 16'd1, 32'd1, 1'b1));
      pending_reqs.push_back(make_req(sih_pkg::CMD_LEGACY, 8'd5, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_INIT, 8'd0, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_ALLOC, 8'd0, 16'd0, 32'd0, 1'b0));
      wait_drained();
      write_apic(1'b1);
      mdl_apic = 1'b1;

      pending_reqs.push_back(make_req(sih_pkg::CMD_ALLOC, 8'hff, 16'hffff, 32'hffffffff, 1'b1));
      pending_reqs.push_back(make_req(sih_pkg::CMD_ALLOC, 8'd0, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_REQUEST, 8'd3, 16'd0, 32'd7, 1'b1));
      pending_reqs.push_back(make_req(sih_pkg::CMD_REQUEST, 8'd1, 16'd9, 32'd7, 1'b1));
      pending_reqs.push_back(make_req(sih_pkg::CMD_REQUEST, 8'd3, 16'hffff, 32'hffffffff, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_REQUEST, 8'd3, 16'hffff, 32'hffffffff, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_REQUEST, 8'd3, 16'd2, 32'd2, 1'b1));
      for (int i = 1; i <= 9; i++)
         pending_reqs.push_back(make_req(sih_pkg::CMD_REQUEST, 8'd64, 16'(i), 32'(i), 1'b1));
      pending_reqs.push_back(make_req(sih_pkg::CMD_RELEASE, 8'd64, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_MSI, 8'd64, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_MSI, 8'd10, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_LEGACY, 8'd0, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_LEGACY, 8'd3, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_LEGACY, 8'd16, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_FREE, 8'd3, 16'hffff, 32'hffffffff, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_FREE, 8'd3, 16'hffff, 32'hffffffff, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_RSVD, 8'd3, 16'd1, 32'd1, 1'b1));
      hold_go = 1'b1;
      wait_drained();

      for (int i = 1; i <= 8; i++)
         pending_reqs.push_back(make_req(sih_pkg::CMD_FREE, 8'd64, 16'(i), 32'(i), 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_RELEASE, 8'd64, 16'd0, 32'd0, 1'b0));
      pending_reqs.push_back(make_req(sih_pkg::CMD_RELEASE, 8'd200, 16'd0, 32'd0, 1'b0));
      queue_random(35);
      wait_drained();
      write_apic(1'b0);
      mdl_apic = 1'b0;
      queue_random(15);
      wait_drained();
      write_apic(1'b1);
      mdl_apic = 1'b1;
      queue_random(40);
      wait_drained();

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
